@@ rtl/assert_macros.svh @@
// assertion helpers for the assertion checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lcbf_pkg.sv @@
package lcbf_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int COUNT_W    = $clog2(MAX_PIXELS + 1);
   localparam int TOTAL_W    = $clog2(64'(255) * MAX_PIXELS + 1);
   localparam int STEP_W     = $clog2(TOTAL_W);

   localparam logic [2:0] CHANNELS_ACTIVE = 3'd4;

   localparam logic ACTION_ACCUM = 1'b0;
   localparam logic ACTION_FILL  = 1'b1;

   localparam logic KIND_COLOR = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   localparam logic [7:0] BYTE_MAX = 8'd255;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_STORE,
      ST_EMIT
   } lcbf_state_type;

   typedef struct packed {
      logic       pix_accept;
      logic       div_load;
      logic [1:0] load_ch;
      logic       div_step;
      logic       div_store;
      logic [1:0] store_ch;
      logic       color_emit;
   } lcbf_cmd_type;

   typedef struct packed {
      logic active;
      logic count_zero;
      logic out_free;
   } lcbf_status_type;

endpackage

@@ rtl/lcbf_req_if.sv @@
interface lcbf_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last;

   modport source (output valid, action, red, green, blue, alpha, last, input ready);
   modport sink   (input valid, action, red, green, blue, alpha, last, output ready);
endinterface

@@ rtl/lcbf_rsp_if.sv @@
interface lcbf_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;

   modport source (output valid, kind, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink   (input valid, kind, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

@@ rtl/lcbf_ctrl.sv @@
module lcbf_ctrl
   import lcbf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_action,
   input  logic            req_last,
   output logic            req_ready,
   input  lcbf_status_type status,
   output lcbf_cmd_type    cmd
);

   lcbf_state_type    state_ff, state_in;
   logic [1:0]        ch_ff, ch_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              step_done;

   assign step_done = (step_ff == STEP_W'(TOTAL_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= CH_RED;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ready && req_valid && req_action == ACTION_ACCUM && req_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.active || status.count_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (ch_ff == CH_BLUE) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.store_ch   = ch_ff;
      cmd.load_ch    = ch_ff;
      ch_in          = ch_ff;
      step_in        = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = status.out_free;
            cmd.pix_accept = status.out_free && req_valid;
         end
         ST_CHECK: begin
            if (status.active && !status.count_zero) begin
               cmd.div_load = 1'b1;
               cmd.load_ch  = CH_RED;
               ch_in        = CH_RED;
               step_in      = '0;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
         end
         ST_STORE: begin
            cmd.div_store = 1'b1;
            if (ch_ff != CH_BLUE) begin
               cmd.div_load = 1'b1;
               cmd.load_ch  = ch_ff + 1'b1;
               ch_in        = ch_ff + 1'b1;
               step_in      = '0;
            end
         end
         ST_EMIT: begin
            cmd.color_emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/lcbf_dp.sv @@
module lcbf_dp
   import lcbf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_write_data,
   input  logic            req_action,
   input  logic [7:0]      req_red,
   input  logic [7:0]      req_green,
   input  logic [7:0]      req_blue,
   input  logic [7:0]      req_alpha,
   input  lcbf_cmd_type    cmd,
   output lcbf_status_type status,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic            rsp_kind,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   output logic [7:0]      rsp_alpha
);

   logic [2:0]         chan_count_ff;
   logic [TOTAL_W-1:0] red_total_ff, green_total_ff, blue_total_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [7:0]         fill_red_ff, fill_green_ff, fill_blue_ff;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [TOTAL_W-1:0] quo_ff, quo_in;
   logic [7:0]         avg_red_ff, avg_green_ff, avg_blue_ff;
   logic               up_red_ff, up_green_ff, up_blue_ff;
   logic               out_valid_ff;
   logic               out_kind_ff;
   logic [7:0]         out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;

   logic               active;
   logic               counted;
   logic [TOTAL_W-1:0] dividend;
   logic [COUNT_W:0]   trial;
   logic [7:0]         lo, hi;
   logic [8:0]         sum_lh;
   logic [7:0]         con_red, con_green, con_blue;
   logic [7:0]         col_red, col_green, col_blue;

   function automatic logic [7:0] contrast(input logic [8:0] s, input logic [7:0] avg,
                                           input logic up);
      logic [8:0] ceil_avg;
      logic [8:0] diff;
      ceil_avg = {1'b0, avg} + {8'd0, up};
      diff     = s - ceil_avg;
      return (s > ceil_avg) ? diff[7:0] : 8'd0;
   endfunction

   assign active            = (chan_count_ff == CHANNELS_ACTIVE);
   assign counted           = active && (req_alpha != 8'd0) &&
                              (count_ff < COUNT_W'(MAX_PIXELS));
   assign status.active     = active;
   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= CHANNELS_ACTIVE;
      end else if (csr_write_enable) begin
         chan_count_ff <= csr_write_data;
      end
   end

   // accumulate pass
   always_ff @(posedge clock) begin
      if (reset) begin
         red_total_ff   <= '0;
         green_total_ff <= '0;
         blue_total_ff  <= '0;
         count_ff       <= '0;
      end else if (cmd.color_emit) begin
         red_total_ff   <= '0;
         green_total_ff <= '0;
         blue_total_ff  <= '0;
         count_ff       <= '0;
      end else if (cmd.pix_accept && req_action == ACTION_ACCUM && counted) begin
         red_total_ff   <= red_total_ff + TOTAL_W'(req_red);
         green_total_ff <= green_total_ff + TOTAL_W'(req_green);
         blue_total_ff  <= blue_total_ff + TOTAL_W'(req_blue);
         count_ff       <= count_ff + 1'b1;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      case (cmd.load_ch)
         CH_RED:   dividend = red_total_ff;
         CH_GREEN: dividend = green_total_ff;
         default:  dividend = blue_total_ff;
      endcase
   end

   assign trial = {rem_ff, quo_ff[TOTAL_W-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, count_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, count_ff});
            quo_in = {quo_ff[TOTAL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[TOTAL_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.div_store) begin
         case (cmd.store_ch)
            CH_RED: begin
               avg_red_ff <= quo_ff[7:0];
               up_red_ff  <= (rem_ff != '0);
            end
            CH_GREEN: begin
               avg_green_ff <= quo_ff[7:0];
               up_green_ff  <= (rem_ff != '0);
            end
            default: begin
               avg_blue_ff <= quo_ff[7:0];
               up_blue_ff  <= (rem_ff != '0);
            end
         endcase
      end
   end

   // contrast color
   always_comb begin
      lo = avg_red_ff;
      hi = avg_red_ff;
      if (avg_green_ff < lo) lo = avg_green_ff;
      if (avg_blue_ff < lo)  lo = avg_blue_ff;
      if (avg_green_ff > hi) hi = avg_green_ff;
      if (avg_blue_ff > hi)  hi = avg_blue_ff;
   end

   assign sum_lh    = {1'b0, lo} + {1'b0, hi};
   assign con_red   = contrast(sum_lh, avg_red_ff, up_red_ff);
   assign con_green = contrast(sum_lh, avg_green_ff, up_green_ff);
   assign con_blue  = contrast(sum_lh, avg_blue_ff, up_blue_ff);

   always_comb begin
      if (!active) begin
         col_red   = 8'd0;
         col_green = 8'd0;
         col_blue  = 8'd0;
      end else if (count_ff == '0) begin
         col_red   = BYTE_MAX;
         col_green = BYTE_MAX;
         col_blue  = BYTE_MAX;
      end else begin
         col_red   = con_red;
         col_green = con_green;
         col_blue  = con_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_red_ff   <= BYTE_MAX;
         fill_green_ff <= BYTE_MAX;
         fill_blue_ff  <= BYTE_MAX;
      end else if (cmd.color_emit && active) begin
         fill_red_ff   <= col_red;
         fill_green_ff <= col_green;
         fill_blue_ff  <= col_blue;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.color_emit || (cmd.pix_accept && req_action == ACTION_FILL)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.color_emit) begin
         out_kind_ff  <= KIND_COLOR;
         out_red_ff   <= col_red;
         out_green_ff <= col_green;
         out_blue_ff  <= col_blue;
         out_alpha_ff <= BYTE_MAX;
      end else if (cmd.pix_accept && req_action == ACTION_FILL) begin
         out_kind_ff <= KIND_PIXEL;
         if (active && req_alpha == 8'd0) begin
            out_red_ff   <= fill_red_ff;
            out_green_ff <= fill_green_ff;
            out_blue_ff  <= fill_blue_ff;
            out_alpha_ff <= BYTE_MAX;
         end else begin
            out_red_ff   <= req_red;
            out_green_ff <= req_green;
            out_blue_ff  <= req_blue;
            out_alpha_ff <= req_alpha;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_red   = out_red_ff;
   assign rsp_green = out_green_ff;
   assign rsp_blue  = out_blue_ff;
   assign rsp_alpha = out_alpha_ff;

endmodule

@@ rtl/logo_contrast_background_fill_unit.sv @@
// Contrast background fill for an RGBA logo streamed in two passes.
// req_bus carries one pixel per transfer: action 0 is the accumulate pass,
// action 1 the fill pass, last marks the final pixel of a pass.
// rsp_bus carries results: kind 0 is the contrast color, kind 1 a filled pixel.
// csr_write_enable/csr_write_data set channel_count; any value but 4 bypasses.
// Accumulate pixels that are not last give no result; a new pixel is taken while the output is free.
// Fill pixels give a registered result that shows in the cycle after the transfer.
// The last accumulate pixel starts the color computation: a check state, then
// a shared bit-serial divider runs the three channels in turn, each giving a
// TOTAL_W-bit quotient bit by bit and then a store state, then an emit state
// that waits for a free output, the color showing in the cycle after emit;
// empty or bypassed images pass through check and emit only.
// No pixel is taken while the color is being computed.
// A single output register holds each result; while the receiver stalls, a
// new pixel is taken only once the held result can leave in the same cycle.
// Reset clears the sums and count, sets the fill color to white and
// channel_count to 4, and drops rsp valid.
module logo_contrast_background_fill_unit
   import lcbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   lcbf_req_if.sink          req_bus,
   lcbf_rsp_if.source        rsp_bus,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_write_data
);

   lcbf_cmd_type    cmd;
   lcbf_status_type status;

   lcbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_last   (req_bus.last),
      .req_ready  (req_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   lcbf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_action       (req_bus.action),
      .req_red          (req_bus.red),
      .req_green        (req_bus.green),
      .req_blue         (req_bus.blue),
      .req_alpha        (req_bus.alpha),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_kind         (rsp_bus.kind),
      .rsp_red          (rsp_bus.out_red),
      .rsp_green        (rsp_bus.out_green),
      .rsp_blue         (rsp_bus.out_blue),
      .rsp_alpha        (rsp_bus.out_alpha)
   );

endmodule

@@ rtl/lcbf_checker.sv @@
`include "assert_macros.svh"

module lcbf_assert_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_action,
   input logic [7:0] req_red,
   input logic [7:0] req_alpha,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha
);

   logic req_xfer;
   logic rsp_stall;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_red) && $stable(rsp_kind) && $stable(rsp_alpha), "stalled response changed")
   `ASSERT_NEXT(a_fill_result, clock, reset, req_xfer && req_action, rsp_valid && rsp_kind, "fill pixel gave no result")
   `ASSERT_NEXT(a_opaque_pass, clock, reset, req_xfer && req_action && req_alpha != 8'd0, rsp_red == $past(req_red) && rsp_alpha == $past(req_alpha), "opaque pixel altered")
   `ASSERT_NEXT(a_accum_silent, clock, reset, req_xfer && !req_action && !req_last && !rsp_stall, !rsp_valid, "accumulate pixel gave a result")
   `ASSERT_IMPLIES(a_no_take_stalled, clock, reset, rsp_stall && req_xfer, 1'b0, "pixel taken while output blocked")

endmodule

bind logo_contrast_background_fill_unit lcbf_assert_checker u_lcbf_assert_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_action (req_bus.action),
   .req_red    (req_bus.red),
   .req_alpha  (req_bus.alpha),
   .req_last   (req_bus.last),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_kind   (rsp_bus.kind),
   .rsp_red    (rsp_bus.out_red),
   .rsp_alpha  (rsp_bus.out_alpha)
);

@@ test/lcbf_checker.sv @@
module lcbf_checker
   import lcbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lcbf_req_if        req_bus,
   lcbf_rsp_if        rsp_bus,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data,
   output int         mismatch_total,
   output int         rsp_due_count,
   output int         colors_seen,
   output int         pixels_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } lcbf_rsp_type;

   lcbf_rsp_type rsp_due_q[$];
   lcbf_rsp_type got_rsp;
   lcbf_rsp_type want_rsp;
   logic [2:0]  channels;
   logic [23:0] red_sum;
   logic [23:0] green_sum;
   logic [23:0] blue_sum;
   logic [16:0] opaque_n;
   logic [7:0]  fill_red;
   logic [7:0]  fill_green;
   logic [7:0]  fill_blue;

   // max(0, lo + hi - ceil(total / n))
   function automatic logic [7:0] contrast_byte(longint unsigned lo, longint unsigned hi,
                                                longint unsigned total, longint unsigned n);
      longint unsigned up;
      up = (total + n - 1) / n;
      return (lo + hi > up) ? 8'(lo + hi - up) : 8'd0;
   endfunction

   task automatic predict_pixel(input logic action, input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue, input logic [7:0] alpha,
                                input logic last);
      lcbf_rsp_type    rsp;
      logic            active;
      longint unsigned avg_r, avg_g, avg_b, lo, hi;
      active = (channels == CHANNELS_ACTIVE);
      if (action == ACTION_FILL) begin
         if (active && alpha == 8'd0) begin
            rsp = '{KIND_PIXEL, fill_red, fill_green, fill_blue, BYTE_MAX};
         end else begin
            rsp = '{KIND_PIXEL, red, green, blue, alpha};
         end
         rsp_due_q.push_back(rsp);
      end else begin
         if (active && alpha != 8'd0 && opaque_n < MAX_PIXELS) begin
            red_sum   += red;
            green_sum += green;
            blue_sum  += blue;
            opaque_n  += 1;
         end
         if (last) begin
            if (!active) begin
               rsp = '{KIND_COLOR, 8'd0, 8'd0, 8'd0, BYTE_MAX};
            end else begin
               rsp = '{KIND_COLOR, BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX};
               if (opaque_n != 0) begin
                  avg_r = red_sum / opaque_n;
                  avg_g = green_sum / opaque_n;
                  avg_b = blue_sum / opaque_n;
                  lo = avg_r;
                  hi = avg_r;
                  if (avg_g < lo) lo = avg_g;
                  if (avg_b < lo) lo = avg_b;
                  if (avg_g > hi) hi = avg_g;
                  if (avg_b > hi) hi = avg_b;
                  rsp.red   = contrast_byte(lo, hi, red_sum, opaque_n);
                  rsp.green = contrast_byte(lo, hi, green_sum, opaque_n);
                  rsp.blue  = contrast_byte(lo, hi, blue_sum, opaque_n);
               end
               fill_red   = rsp.red;
               fill_green = rsp.green;
               fill_blue  = rsp.blue;
            end
            red_sum   = '0;
            green_sum = '0;
            blue_sum  = '0;
            opaque_n  = '0;
            rsp_due_q.push_back(rsp);
         end
      end
   endtask

   task automatic report_mismatch(input bit had_want, input lcbf_rsp_type want,
                                  input lcbf_rsp_type got);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         if (had_want) begin
            $display("%0t mismatch: expected kind %0d rgba %02h %02h %02h %02h, got kind %0d rgba %02h %02h %02h %02h",
                     $time, want.kind, want.red, want.green, want.blue, want.alpha,
                     got.kind, got.red, got.green, got.blue, got.alpha);
         end else begin
            $display("%0t mismatch: nothing expected, got kind %0d rgba %02h %02h %02h %02h",
                     $time, got.kind, got.red, got.green, got.blue, got.alpha);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_due_q.delete();
         channels       = CHANNELS_ACTIVE;
         red_sum        = '0;
         green_sum      = '0;
         blue_sum       = '0;
         opaque_n       = '0;
         fill_red       = BYTE_MAX;
         fill_green     = BYTE_MAX;
         fill_blue      = BYTE_MAX;
         mismatch_total = 0;
         colors_seen    = 0;
         pixels_seen    = 0;
      end else begin
         // result side first so an early result cannot hide behind a new prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_rsp = '{rsp_bus.kind, rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                        rsp_bus.out_alpha};
            if (rsp_due_q.size() == 0) begin
               report_mismatch(1'b0, got_rsp, got_rsp);
            end else begin
               want_rsp = rsp_due_q.pop_front();
               if (got_rsp != want_rsp) report_mismatch(1'b1, want_rsp, got_rsp);
               if (want_rsp.kind == KIND_COLOR) colors_seen++;
               else pixels_seen++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_pixel(req_bus.action, req_bus.red, req_bus.green, req_bus.blue,
                          req_bus.alpha, req_bus.last);
         end
         if (csr_write_enable) channels = csr_write_data;
      end
      rsp_due_count <= rsp_due_q.size();
   end

endmodule

@@ test/tb_top.sv @@
module tb_top;
   import lcbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS     = 725;
   localparam int QUIET_ITEMS      = 120;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES    = 120;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [2:0] csr_write_data;

   int mismatch_total;
   int rsp_due_count;
   int colors_seen;
   int pixels_seen;
   int items_sent;
   bit quiet;
   bit long_hold_req;

   lcbf_req_if req_bus();
   lcbf_rsp_if rsp_bus();

   logo_contrast_background_fill_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lcbf_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_total   (mismatch_total),
      .rsp_due_count    (rsp_due_count),
      .colors_seen      (colors_seen),
      .pixels_seen      (pixels_seen)
   );

   always #4 clock = ~clock;

   initial begin
      #8_000_000;
      $display("FAIL logo_contrast_background_fill_unit");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one pixel transfer, called at a rising edge
   task automatic send_pixel(input logic action, input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] alpha,
                             input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= action;
      req_bus.red    <= red;
      req_bus.green  <= green;
      req_bus.blue   <= blue;
      req_bus.alpha  <= alpha;
      req_bus.last   <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (rsp_due_count != 0) @(posedge clock);
   endtask

   task automatic set_channels(input logic [2:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] pick_alpha(input int zero_odds);
      return ($urandom_range(1, zero_odds) == 1) ? 8'd0 : 8'($urandom_range(1, 255));
   endfunction

   // accumulate pass then fill pass, random content
   task automatic send_image();
      int  n_acc;
      int  n_fill;
      bit  all_clear;
      n_acc     = $urandom_range(1, 10);
      n_fill    = $urandom_range(1, 10);
      all_clear = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n_acc; i++) begin
         send_pixel(ACTION_ACCUM, 8'($urandom), 8'($urandom), 8'($urandom),
                    all_clear ? 8'd0 : pick_alpha(4), i == n_acc - 1);
      end
      for (int i = 0; i < n_fill; i++) begin
         send_pixel(ACTION_FILL, 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(3),
                    i == n_fill - 1);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4)) begin
         send_pixel(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom));
      end
   endtask

   initial begin
      int  random_base;
      bit  hold_done;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= CHANNELS_ACTIVE;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACTION_ACCUM;
      req_bus.red      <= 8'd0;
      req_bus.green    <= 8'd0;
      req_bus.blue     <= 8'd0;
      req_bus.alpha    <= 8'd0;
      req_bus.last     <= 1'b0;
      quiet         = 1'b0;
      long_hold_req = 1'b0;
      hold_done     = 1'b0;
      items_sent    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill before any accumulate uses white
      send_pixel(ACTION_FILL, 8'h5a, 8'ha5, 8'h3c, 8'h00, 1'b0);
      send_pixel(ACTION_FILL, 8'hff, 8'h00, 8'hff, 8'hff, 1'b1);
      // empty image
      send_pixel(ACTION_ACCUM, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1);
      send_pixel(ACTION_ACCUM, 8'hff, 8'h00, 8'h00, 8'h01, 1'b0);
      send_pixel(ACTION_ACCUM, 8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
      send_pixel(ACTION_ACCUM, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1);
      send_pixel(ACTION_FILL, 8'h01, 8'h02, 8'h03, 8'h00, 1'b0);
      send_pixel(ACTION_FILL, 8'haa, 8'h55, 8'haa, 8'h01, 1'b1);
      send_pixel(ACTION_ACCUM, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1);
      send_pixel(ACTION_ACCUM, 8'h80, 8'h40, 8'h20, 8'h7f, 1'b0);
      send_pixel(ACTION_ACCUM, 8'h7f, 8'hbf, 8'hdf, 8'hfe, 1'b1);
      send_pixel(ACTION_FILL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      // bypass settings keep the fill color
      set_channels(3'd1);
      send_pixel(ACTION_ACCUM, 8'h11, 8'h22, 8'h33, 8'hff, 1'b0);
      send_pixel(ACTION_ACCUM, 8'h44, 8'h55, 8'h66, 8'hff, 1'b1);
      send_pixel(ACTION_FILL, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0);
      set_channels(3'd0);
      send_pixel(ACTION_ACCUM, 8'hc3, 8'h3c, 8'h99, 8'h00, 1'b1);
      send_pixel(ACTION_FILL, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
      set_channels(3'd7);
      send_pixel(ACTION_ACCUM, 8'h01, 8'h80, 8'hfe, 8'h10, 1'b1);
      send_pixel(ACTION_FILL, 8'h80, 8'h80, 8'h80, 8'h00, 1'b1);
      set_channels(3'd3);
      send_pixel(ACTION_ACCUM, 8'h08, 8'h04, 8'h02, 8'h20, 1'b1);
      set_channels(CHANNELS_ACTIVE);
      send_pixel(ACTION_FILL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(ACTION_ACCUM, 8'hff, 8'h00, 8'h80, 8'h01, 1'b1);
      send_pixel(ACTION_FILL, 8'h33, 8'h33, 8'h33, 8'h00, 1'b1);

      random_base = items_sent;
      while (items_sent < random_base + RANDOM_ITEMS) begin
         quiet = (items_sent >= random_base + RANDOM_ITEMS - QUIET_ITEMS);
         if (!hold_done && items_sent >= random_base + 300) begin
            // stall the result side while pixels keep coming
            hold_done     = 1'b1;
            long_hold_req = 1'b1;
            repeat (16) begin
               send_pixel(ACTION_FILL, 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(3),
                          1'b0);
            end
         end else begin
            case ($urandom_range(0, 19))
               0: begin
                  if (!quiet) begin
                     set_channels(($urandom_range(0, 1) == 0) ? CHANNELS_ACTIVE
                                                                : 3'($urandom_range(0, 7)));
                  end
               end
               1: begin
                  if (!quiet) wait_drained();
               end
               2, 3: send_noise();
               default: send_image();
            endcase
         end
      end

      if (!quiet) set_channels(CHANNELS_ACTIVE);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d pixels, checked %0d colors and %0d fill pixels",
               items_sent, colors_seen, pixels_seen);
      $display("channel_count went through 0, 1, 3, 4, 7 and random values, with long result stall");
      if (mismatch_total == 0 && rsp_due_count == 0) begin
         $display("PASS logo_contrast_background_fill_unit");
      end else begin
         $display("FAIL logo_contrast_background_fill_unit");
      end
      $finish;
   end

endmodule
